@@ sv/zbuffer_triangle_rasterizer_unit_defines.svh @@
// Assertion macros for the z-buffer triangle rasterizer.
// Included by the top level only; relies on clk_i and rst_ni in scope.
`ifndef ZBUFFER_TRIANGLE_RASTERIZER_UNIT_DEFINES_SVH
`define ZBUFFER_TRIANGLE_RASTERIZER_UNIT_DEFINES_SVH

`define ZBTR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zbtr assertion failed");

`define ZBTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zbtr assertion failed");

`endif

@@ sv/zbtr_pkg.sv @@
// Shared constants for the z-buffer triangle rasterizer.
// No dependencies.
package zbtr_pkg;
  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;
  localparam int XW            = $clog2(SCREEN_WIDTH);
  localparam int YW            = $clog2(SCREEN_HEIGHT);
  localparam int DEPTH_ENTRIES = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(DEPTH_ENTRIES);
  localparam logic signed [15:0] DEPTH_ONE = 16'sd16384;
  localparam logic signed [15:0] X_LIMIT = 16'((SCREEN_WIDTH - 1) * 16);
  localparam logic signed [15:0] Y_LIMIT = 16'((SCREEN_HEIGHT - 1) * 16);
  localparam int AREA_LIMIT = 2;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;
  localparam logic [1:0] SLOT_NONE = 2'd3;
endpackage

@@ sv/zbtr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module zbtr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

@@ sv/zbuffer_triangle_rasterizer_unit.sv @@
// Z-buffered bounding-box triangle rasterizer, top level.
// Depends on zbtr_pkg, zbtr_ram and zbuffer_triangle_rasterizer_unit_defines.svh.
//
// An item is taken when start_i is high and busy_o is low. A load (op_i low)
// writes one vertex (none for slot 3) and restarts the box scan; it passes
// through ST_BOX and gives no result. A step (op_i high) visits one pixel and
// gives one result on the pixel and gray ports, marked by result_valid_o for a
// single cycle; the receiver cannot hold it off and must take that transfer.
// A step on a finished scan answers in the next cycle. A covered pixel passes
// through the edge products and weights, the weighted sums, the shared
// restoring divider that yields depth and gray at one quotient bit per cycle,
// and the depth compare and write. An uncovered pixel skips the sums and divider.
// The depth buffer is a single RAM; each pixel reads its entry once and
// writes it back at most once, so accesses never overlap.
// After reset a clearing pass writes 1.0 into all 65536 depth entries, one
// per cycle; busy_o stays high until the pass ends. Reset also zeroes the
// vertices and marks the scan finished.
module zbuffer_triangle_rasterizer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              op_i,
  input  logic [1:0]        vertex_slot_i,
  input  logic signed [15:0] vert_x_i,
  input  logic signed [15:0] vert_y_i,
  input  logic signed [15:0] vert_depth_i,
  input  logic [7:0]        vert_shade_i,
  output logic              result_valid_o,
  output logic              pixel_write_o,
  output logic [7:0]        pixel_x_o,
  output logic [7:0]        pixel_y_o,
  output logic [7:0]        gray_o,
  output logic              last_o
);
  `include "zbuffer_triangle_rasterizer_unit_defines.svh"

  localparam int DW = 18;
  localparam int PW = 36;
  localparam int UW = 40;
  localparam int NW = 60;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BOX, ST_DIFF, ST_MUL, ST_SUM, ST_NORM, ST_NUM, ST_ACC,
    ST_DIV, ST_FIN
  } state_e;

  state_e state_q;
  logic   clr_q;
  logic [zbtr_pkg::ADDR_W-1:0] clr_addr_q;
  logic   done_q;
  logic [zbtr_pkg::XW-1:0] cx_q, xhi_q;
  logic [zbtr_pkg::YW-1:0] cy_q, ylo_q, yhi_q;

  logic signed [15:0] vx_q [3];
  logic signed [15:0] vy_q [3];
  logic signed [15:0] vz_q [3];
  logic [7:0]         vs_q [3];

  logic signed [DW-1:0] dx1_q, dy1_q, dx2_q, dy2_q, ex_q, ey_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [UW-1:0] ux_q, uy_q, uz_q, w0_q, w1_q, w2_q, d_q;
  logic                 cov_q;
  logic signed [NW-1:0] m0_q, m1_q, m2_q, g0_q, g1_q, g2_q;
  logic [NW-1:0]        rem_q, grem_q;
  logic [15:0]          q_q, gq_q;
  logic                 neg_q;
  logic [3:0]           k_q;
  logic [15:0]          stored_q;

  logic [zbtr_pkg::ADDR_W-1:0] pix_addr;
  logic                        ram_we;
  logic [zbtr_pkg::ADDR_W-1:0] ram_waddr;
  logic [15:0]                 ram_wdata;
  logic [15:0]                 ram_rdata;
  logic                        take;

  logic signed [15:0] mnx, mxx, mny, mxy;
  logic signed [15:0] cmnx, cmxx, cmny, cmxy;
  logic [11:0]        bxlo, bxhi, bylo, byhi;
  logic               box_empty;

  logic signed [UW-1:0] nux, nuy, nuz, nw0;
  logic                 covered;
  logic signed [NW-1:0] num, gsum;
  logic [NW-1:0]        dsh;
  logic signed [17:0]   frag;
  logic                 depth_pass;
  logic                 is_last;

  assign take    = start_i && !busy_o;
  assign busy_o  = clr_q || (state_q != ST_IDLE);
  assign pix_addr = zbtr_pkg::ADDR_W'(cy_q) * zbtr_pkg::ADDR_W'(zbtr_pkg::SCREEN_WIDTH)
                  + zbtr_pkg::ADDR_W'(cx_q);

  always_comb begin
    mnx = vx_q[0]; mxx = vx_q[0]; mny = vy_q[0]; mxy = vy_q[0];
    for (int i = 1; i < 3; i++) begin
      if (vx_q[i] < mnx) mnx = vx_q[i];
      if (vx_q[i] > mxx) mxx = vx_q[i];
      if (vy_q[i] < mny) mny = vy_q[i];
      if (vy_q[i] > mxy) mxy = vy_q[i];
    end
    cmnx = (mnx < 16'sd0) ? 16'sd0 : mnx;
    cmny = (mny < 16'sd0) ? 16'sd0 : mny;
    cmxx = (mxx > zbtr_pkg::X_LIMIT) ? zbtr_pkg::X_LIMIT : mxx;
    cmxy = (mxy > zbtr_pkg::Y_LIMIT) ? zbtr_pkg::Y_LIMIT : mxy;
    bxlo = cmnx[15:4];
    bxhi = cmxx[15:4];
    bylo = cmny[15:4];
    byhi = cmxy[15:4];
    box_empty = cmxx[15] || cmxy[15] || (bxlo > bxhi) || (bylo > byhi);
  end

  always_comb begin
    nux = UW'(ux_q);
    nuy = UW'(uy_q);
    nuz = UW'(uz_q);
    if (uz_q < 0) begin
      nux = -ux_q;
      nuy = -uy_q;
      nuz = -uz_q;
    end
    nw0 = nuz - nux - nuy;
    covered = (nuz > UW'(zbtr_pkg::AREA_LIMIT)) && (nux >= 0) && (nuy >= 0) && (nw0 >= 0);
  end

  assign num  = m0_q + m1_q + m2_q;
  assign gsum = g0_q + g1_q + g2_q;
  assign dsh  = NW'(d_q) << k_q;

  always_comb begin
    if (neg_q) begin
      frag = -(18'(q_q) + 18'(rem_q != '0));
    end else begin
      frag = 18'(q_q);
    end
    depth_pass = cov_q && (18'($signed(stored_q)) > frag);
    is_last = (cx_q == xhi_q) && (cy_q == yhi_q);
  end

  assign ram_we    = clr_q || ((state_q == ST_FIN) && depth_pass);
  assign ram_waddr = clr_q ? clr_addr_q : pix_addr;
  assign ram_wdata = clr_q ? zbtr_pkg::DEPTH_ONE : frag[15:0];

  zbtr_ram #(
    .WIDTH(16),
    .DEPTH(zbtr_pkg::DEPTH_ENTRIES)
  ) u_depth_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (state_q == ST_DIFF),
    .raddr_i(pix_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      clr_q          <= 1'b1;
      clr_addr_q     <= '0;
      done_q         <= 1'b1;
      cx_q           <= '0;
      cy_q           <= '0;
      xhi_q          <= '0;
      ylo_q          <= '0;
      yhi_q          <= '0;
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
        vz_q[i] <= '0;
        vs_q[i] <= '0;
      end
      result_valid_o <= 1'b0;
      pixel_write_o  <= 1'b0;
      pixel_x_o      <= '0;
      pixel_y_o      <= '0;
      gray_o         <= '0;
      last_o         <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == zbtr_pkg::ADDR_W'(zbtr_pkg::DEPTH_ENTRIES - 1)) begin
          clr_q <= 1'b0;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            if (op_i == zbtr_pkg::OP_LOAD) begin
              if (vertex_slot_i != zbtr_pkg::SLOT_NONE) begin
                vx_q[vertex_slot_i] <= vert_x_i;
                vy_q[vertex_slot_i] <= vert_y_i;
                vz_q[vertex_slot_i] <= vert_depth_i;
                vs_q[vertex_slot_i] <= vert_shade_i;
              end
              state_q <= ST_BOX;
            end else if (done_q) begin
              result_valid_o <= 1'b1;
              pixel_write_o  <= 1'b0;
              pixel_x_o      <= '0;
              pixel_y_o      <= '0;
              gray_o         <= '0;
              last_o         <= 1'b1;
            end else begin
              state_q <= ST_DIFF;
            end
          end
        end
        ST_BOX: begin
          done_q <= 1'b1;
          if (!box_empty) begin
            xhi_q  <= bxhi[zbtr_pkg::XW-1:0];
            ylo_q  <= bylo[zbtr_pkg::YW-1:0];
            yhi_q  <= byhi[zbtr_pkg::YW-1:0];
            cx_q   <= bxlo[zbtr_pkg::XW-1:0];
            cy_q   <= bylo[zbtr_pkg::YW-1:0];
            done_q <= 1'b0;
          end
          state_q <= ST_IDLE;
        end
        ST_DIFF: state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_NORM;
        ST_NORM: state_q <= covered ? ST_NUM : ST_FIN;
        ST_NUM:  state_q <= ST_ACC;
        ST_ACC:  state_q <= ST_DIV;
        ST_DIV: begin
          if (k_q == '0) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          result_valid_o <= 1'b1;
          pixel_write_o  <= depth_pass;
          pixel_x_o      <= 8'(cx_q);
          pixel_y_o      <= 8'(cy_q);
          gray_o         <= depth_pass ? gq_q[7:0] : 8'd0;
          last_o         <= is_last;
          if (cy_q < yhi_q) begin
            cy_q <= cy_q + 1'b1;
          end else if (cx_q < xhi_q) begin
            cx_q <= cx_q + 1'b1;
            cy_q <= ylo_q;
          end else begin
            done_q <= 1'b1;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_DIFF: begin
        dx1_q <= DW'(vx_q[1]) - DW'(vx_q[0]);
        dy1_q <= DW'(vy_q[1]) - DW'(vy_q[0]);
        dx2_q <= DW'(vx_q[2]) - DW'(vx_q[0]);
        dy2_q <= DW'(vy_q[2]) - DW'(vy_q[0]);
        ex_q  <= DW'(vx_q[0]) - DW'({1'b0, cx_q, 4'b0000});
        ey_q  <= DW'(vy_q[0]) - DW'({1'b0, cy_q, 4'b0000});
      end
      ST_MUL: begin
        stored_q <= ram_rdata;
        p1_q <= dx1_q * ey_q;
        p2_q <= ex_q * dy1_q;
        p3_q <= ex_q * dy2_q;
        p4_q <= dx2_q * ey_q;
        p5_q <= dx2_q * dy1_q;
        p6_q <= dx1_q * dy2_q;
      end
      ST_SUM: begin
        ux_q <= UW'(p1_q) - UW'(p2_q);
        uy_q <= UW'(p3_q) - UW'(p4_q);
        uz_q <= UW'(p5_q) - UW'(p6_q);
      end
      ST_NORM: begin
        w0_q  <= nw0;
        w1_q  <= nuy;
        w2_q  <= nux;
        d_q   <= nuz;
        cov_q <= covered;
      end
      ST_NUM: begin
        m0_q <= vz_q[0] * w0_q;
        m1_q <= vz_q[1] * w1_q;
        m2_q <= vz_q[2] * w2_q;
        g0_q <= $signed({1'b0, vs_q[0]}) * w0_q;
        g1_q <= $signed({1'b0, vs_q[1]}) * w1_q;
        g2_q <= $signed({1'b0, vs_q[2]}) * w2_q;
      end
      ST_ACC: begin
        neg_q  <= num[NW-1];
        rem_q  <= num[NW-1] ? NW'(-num) : NW'(num);
        grem_q <= NW'(gsum);
        q_q    <= '0;
        gq_q   <= '0;
        k_q    <= 4'd15;
      end
      ST_DIV: begin
        if (rem_q >= dsh) begin
          rem_q    <= rem_q - dsh;
          q_q[k_q] <= 1'b1;
        end
        if (grem_q >= dsh) begin
          grem_q    <= grem_q - dsh;
          gq_q[k_q] <= 1'b1;
        end
        k_q <= k_q - 1'b1;
      end
      ST_IDLE, ST_BOX, ST_FIN: begin
        cov_q <= (state_q == ST_FIN) ? 1'b0 : cov_q;
      end
      default: begin
      end
    endcase
  end

  `ZBTR_ASSERT_NEXT(a_load_no_result, take && (op_i == zbtr_pkg::OP_LOAD), !result_valid_o)
  `ZBTR_ASSERT_IMPL(a_ram_write_src, ram_we, clr_q || (state_q == ST_FIN))
  `ZBTR_ASSERT_IMPL(a_gray_only_on_write, result_valid_o && !pixel_write_o, gray_o == 8'd0)
  `ZBTR_ASSERT_IMPL(a_no_step_in_clear, clr_q, state_q == ST_IDLE || state_q == ST_BOX)
endmodule

@@ verif/zbuffer_triangle_rasterizer_unit_tb.sv @@
// Testbench for the z-buffer triangle rasterizer: loads triangles, steps their box scans
// and checks every pixel result against a scoreboard that rasterizes on its own.
// Depends on zbtr_pkg and the zbuffer_triangle_rasterizer_unit top level.
module zbuffer_triangle_rasterizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       wr;
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] gray;
    logic       last;
  } pixel_t;

  class raster_scoreboard;
    int     vx[3], vy[3], vz[3], vs[3];
    int     xlo, xhi, ylo, yhi, cx, cy;
    bit     done;
    shortint zmem[zbtr_pkg::DEPTH_ENTRIES];
    pixel_t pending[$];
    int     mismatches;

    function new();
      foreach (vx[i]) begin
        vx[i] = 0; vy[i] = 0; vz[i] = 0; vs[i] = 0;
      end
      xlo = 0; xhi = 0; ylo = 0; yhi = 0; cx = 0; cy = 0;
      done = 1'b1;
      foreach (zmem[i]) zmem[i] = zbtr_pkg::DEPTH_ONE;
      mismatches = 0;
    endfunction

    function int pixels_left();
      if (done) return 0;
      return (xhi - cx) * (yhi - ylo + 1) + (yhi - cy) + 1;
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q -= 1;
      return q;
    endfunction

    function void restart_box();
      int mnx, mxx, mny, mxy;
      mnx = vx[0]; mxx = vx[0]; mny = vy[0]; mxy = vy[0];
      for (int i = 1; i < 3; i++) begin
        if (vx[i] < mnx) mnx = vx[i];
        if (vx[i] > mxx) mxx = vx[i];
        if (vy[i] < mny) mny = vy[i];
        if (vy[i] > mxy) mxy = vy[i];
      end
      if (mnx < 0) mnx = 0;
      if (mny < 0) mny = 0;
      if (mxx > (zbtr_pkg::SCREEN_WIDTH - 1) * 16) mxx = (zbtr_pkg::SCREEN_WIDTH - 1) * 16;
      if (mxy > (zbtr_pkg::SCREEN_HEIGHT - 1) * 16) mxy = (zbtr_pkg::SCREEN_HEIGHT - 1) * 16;
      done = 1'b1;
      if (mxx < 0 || mxy < 0) return;
      xlo = mnx / 16; xhi = mxx / 16; ylo = mny / 16; yhi = mxy / 16;
      if (xlo > xhi || ylo > yhi) return;
      cx = xlo; cy = ylo;
      done = 1'b0;
    endfunction

    function void note_input(logic op, logic [1:0] slot, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z, logic [7:0] s);
      longint px, py, ux, uy, uz, w0, frag, g;
      pixel_t r;
      int idx;
      if (op == zbtr_pkg::OP_LOAD) begin
        if (slot != zbtr_pkg::SLOT_NONE) begin
          vx[slot] = x; vy[slot] = y; vz[slot] = z; vs[slot] = s;
        end
        restart_box();
        return;
      end
      r = '0;
      if (done) begin
        r.last = 1'b1;
        pending.push_back(r);
        return;
      end
      px = longint'(cx) * 16;
      py = longint'(cy) * 16;
      ux = longint'(vx[1] - vx[0]) * (vy[0] - py) - (vx[0] - px) * longint'(vy[1] - vy[0]);
      uy = (vx[0] - px) * longint'(vy[2] - vy[0]) - longint'(vx[2] - vx[0]) * (vy[0] - py);
      uz = longint'(vx[2] - vx[0]) * longint'(vy[1] - vy[0])
         - longint'(vx[1] - vx[0]) * longint'(vy[2] - vy[0]);
      if (uz < 0) begin
        ux = -ux; uy = -uy; uz = -uz;
      end
      w0 = uz - ux - uy;
      if (uz > zbtr_pkg::AREA_LIMIT && ux >= 0 && uy >= 0 && w0 >= 0) begin
        idx = cx + cy * zbtr_pkg::SCREEN_WIDTH;
        frag = floor_div(longint'(vz[0]) * w0 + longint'(vz[1]) * uy + longint'(vz[2]) * ux, uz);
        if (frag < -32768) frag = -32768;
        if (frag > 32767) frag = 32767;
        if (longint'(zmem[idx]) > frag) begin
          zmem[idx] = shortint'(frag);
          g = floor_div(longint'(vs[0]) * w0 + longint'(vs[1]) * uy + longint'(vs[2]) * ux, uz);
          if (g < 0) g = 0;
          if (g > 255) g = 255;
          r.wr = 1'b1;
          r.gray = g[7:0];
        end
      end
      r.px = cx[7:0];
      r.py = cy[7:0];
      r.last = (cx == xhi && cy == yhi);
      if (cy < yhi) cy++;
      else if (cx < xhi) begin
        cx++;
        cy = ylo;
      end else done = 1'b1;
      pending.push_back(r);
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic op_i = zbtr_pkg::OP_LOAD;
  logic [1:0] vertex_slot_i = '0;
  logic signed [15:0] vert_x_i = '0, vert_y_i = '0, vert_depth_i = '0;
  logic [7:0] vert_shade_i = '0;
  logic busy_o, result_valid_o, pixel_write_o, last_o;
  logic [7:0] pixel_x_o, pixel_y_o, gray_o;

  raster_scoreboard sb = new();
  int  items_sent = 0;
  bit  no_gaps = 1'b0;

  zbuffer_triangle_rasterizer_unit DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result({pixel_write_o, pixel_x_o, pixel_y_o, gray_o, last_o});
  end

  task automatic send_item(logic op, logic [1:0] slot, int x, int y, int z, int s);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    op_i = op;
    vertex_slot_i = slot;
    vert_x_i = x[15:0];
    vert_y_i = y[15:0];
    vert_depth_i = z[15:0];
    vert_shade_i = s[7:0];
    do @(posedge clk_i); while (busy_o);
    sb.note_input(op, slot, x[15:0], y[15:0], z[15:0], s[7:0]);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_vertex(logic [1:0] slot, int x, int y, int z, int s);
    send_item(zbtr_pkg::OP_LOAD, slot, x, y, z, s);
  endtask

  task automatic step_pixels(int n);
    repeat (n) send_item(zbtr_pkg::OP_STEP, $urandom_range(0, 3), $urandom, $urandom,
                         $urandom, $urandom);
  endtask

  task automatic load_triangle(int x0, int y0, int x1, int y1, int x2, int y2,
                               int z0, int z1, int z2, int s0, int s1, int s2);
    load_vertex(0, x0, y0, z0, s0);
    load_vertex(1, x1, y1, z1, s1);
    load_vertex(2, x2, y2, z2, s2);
  endtask

  initial begin
    int bx, by, n, kind;
    int corner[12];
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    step_pixels(1);
    load_triangle(-32768, -32768, 32767, 32767, 0, 0, -32768, 32767, 0, 0, 255, 128);
    step_pixels(2);
    load_triangle(-32768, 100, -500, 32767, -16, -16, 0, 0, 0, 9, 9, 9);
    step_pixels(1);
    load_triangle(16, 16, 32, 32, 48, 48, 0, 0, 0, 1, 2, 3);
    step_pixels(2);
    load_triangle(16, 16, 48, 16, 16, 48, -8192, 8191, 0, 255, 0, 100);
    step_pixels(9);
    load_vertex(zbtr_pkg::SLOT_NONE, 0, 0, 0, 0);
    step_pixels(10);
    load_triangle(4064, 4064, 4080, 4000, 32767, 4090, -32768, -32768, -32768, 255, 255, 255);
    step_pixels(sb.pixels_left() + 1);

    while (items_sent < 550) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) no_gaps = !no_gaps;
      if (kind == 0) begin
        load_vertex($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom);
      end else if (kind == 1) begin
        step_pixels($urandom_range(1, 3));
      end else begin
        if (kind != 2) begin
          bx = $urandom_range(0, 9) == 0 ? $urandom_range(3900, 4200) - 64
                                         : $urandom_range(0, 4000) - 32;
          by = $urandom_range(0, 9) == 0 ? $urandom_range(3900, 4200) - 64
                                         : $urandom_range(0, 4000) - 32;
          for (int i = 0; i < 3; i++) begin
            corner[2 * i] = bx + $urandom_range(0, 96);
            corner[2 * i + 1] = by + $urandom_range(0, 96);
            corner[6 + i] = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) - 32768
                                                     : $urandom_range(0, 32768) - 16384;
            corner[9 + i] = $urandom_range(0, 255);
          end
        end
        load_triangle(corner[0], corner[1], corner[2], corner[3], corner[4], corner[5],
                      corner[6], corner[7], corner[8], corner[9], corner[10], corner[11]);
        n = sb.pixels_left();
        if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
        else n += $urandom_range(0, 1);
        step_pixels(n);
      end
    end

    start_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("zbuffer_triangle_rasterizer_unit_tb OK");
    end else begin
      $display("zbuffer_triangle_rasterizer_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("zbuffer_triangle_rasterizer_unit_tb NOT OK");
    $finish;
  end
endmodule
